// ----- rtl/btmx_pkg.sv -----
// ----------------------------------------------------------------------------
// btmx_pkg: shared types and constants for the binary trie min-xor block
// Key and node-store sizes, item kinds, result codes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

	localparam int KEY_BITS   = 30;
	localparam int NODE_COUNT = 4096;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int ENTRY_W    = 2 * NODE_W;
	localparam int LVL_W      = $clog2(KEY_BITS);
	localparam int CNT_W      = NODE_W + 1;
	localparam int TDATA_W    = ((KEY_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_QUERY  = 2'd2
	} btmx_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} btmx_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_WALK,
		S_WR_PAR,
		S_WR_CHAIN,
		S_DONE
	} btmx_state_t;

	// controller -> datapath
	typedef struct packed {
		logic         load_item;
		logic         clear_trie;
		logic         walk_step;
		logic         set_parent;
		logic         write_parent;
		logic         write_chain;
		logic         load_out;
		btmx_status_t out_status;
	} btmx_cmd_t;

	// datapath -> controller
	typedef struct packed {
		btmx_kind_t kind;
		logic       empty;
		logic       lvl_zero;
		logic       want_miss;
		logic       both_miss;
		logic       fits;
	} btmx_sts_t;

endpackage

`default_nettype wire

// ----- rtl/btmx_dp.sv -----
// ----------------------------------------------------------------------------
// btmx_dp: trie datapath
// Node store (one write, one registered read per cycle), root links in
// flops, walk registers, allocation counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_dp import btmx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          in_kind,
	input  logic [KEY_BITS-1:0] in_key,
	input  btmx_cmd_t           cmd,
	output btmx_sts_t           sts,
	output logic [KEY_BITS-1:0] out_value,
	output logic [1:0]          out_status
);

	// node store: {link1, link0} per node, entry 0 unused (root lives in flops)
	logic [ENTRY_W-1:0]  mem [NODE_COUNT];
	logic [ENTRY_W-1:0]  rd_q;

	btmx_kind_t          kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [NODE_W-1:0]   node_q;
	logic                at_root_q;
	logic [KEY_BITS-1:0] acc_q;
	logic [NODE_W-1:0]   used_q;
	logic [ENTRY_W-1:0]  root_q;
	logic [NODE_W-1:0]   par_node_q;
	logic                par_root_q;
	logic [ENTRY_W-1:0]  par_entry_q;
	logic                par_bit_q;
	logic [NODE_W-1:0]   alloc_q;
	logic [KEY_BITS-1:0] out_value_q;
	btmx_status_t        out_status_q;

	logic [ENTRY_W-1:0]  entry;
	logic                cur_bit;
	logic [NODE_W-1:0]   link_want;
	logic [NODE_W-1:0]   link_other;
	logic                want_miss;
	logic [NODE_W-1:0]   nx;
	logic [LVL_W-1:0]    lvl_m1;
	logic                lvl_zero;
	logic [NODE_W-1:0]   alloc_nx;
	logic [CNT_W-1:0]    need_total;
	logic                wr_en;
	logic [NODE_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0]  wr_data;

	assign entry      = at_root_q ? root_q : rd_q;
	assign cur_bit    = key_q[lvl_q];
	assign link_want  = cur_bit ? entry[ENTRY_W-1:NODE_W] : entry[NODE_W-1:0];
	assign link_other = cur_bit ? entry[NODE_W-1:0] : entry[ENTRY_W-1:NODE_W];
	assign want_miss  = (link_want == '0);
	assign nx         = want_miss ? link_other : link_want;
	assign lvl_m1     = lvl_q - LVL_W'(1);
	assign lvl_zero   = (lvl_q == '0);
	assign alloc_nx   = alloc_q + NODE_W'(1);
	// nodes needed on a miss at this level: lvl + 1
	assign need_total = {1'b0, used_q} + CNT_W'(lvl_q) + CNT_W'(1);

	assign sts.kind      = kind_q;
	assign sts.empty     = (used_q == '0);
	assign sts.lvl_zero  = lvl_zero;
	assign sts.want_miss = want_miss;
	assign sts.both_miss = want_miss && (link_other == '0);
	assign sts.fits      = (need_total <= CNT_W'(NODE_COUNT - 1));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = alloc_q;
		wr_data = '0;
		if (cmd.write_parent && !par_root_q) begin
			wr_en   = 1'b1;
			wr_addr = par_node_q;
			wr_data = par_bit_q ? {alloc_q, par_entry_q[NODE_W-1:0]}
			                    : {par_entry_q[ENTRY_W-1:NODE_W], alloc_q};
		end else if (cmd.write_chain) begin
			wr_en   = 1'b1;
			wr_addr = alloc_q;
			if (lvl_zero) begin
				wr_data = '0;
			end else if (key_q[lvl_m1]) begin
				wr_data = {alloc_nx, {NODE_W{1'b0}}};
			end else begin
				wr_data = {{NODE_W{1'b0}}, alloc_nx};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[nx];
	end

	// trie occupancy and root links
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			root_q <= '0;
		end else begin
			if (cmd.clear_trie) begin
				used_q <= '0;
				root_q <= '0;
			end else begin
				if (cmd.write_parent && par_root_q) begin
					if (par_bit_q) begin
						root_q[ENTRY_W-1:NODE_W] <= alloc_q;
					end else begin
						root_q[NODE_W-1:0] <= alloc_q;
					end
				end
				if (cmd.write_chain && lvl_zero) begin
					used_q <= alloc_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q    <= btmx_kind_t'(in_kind);
			key_q     <= in_key;
			lvl_q     <= LVL_W'(KEY_BITS - 1);
			node_q    <= '0;
			at_root_q <= 1'b1;
			acc_q     <= '0;
		end
		if (cmd.walk_step) begin
			if (want_miss) begin
				acc_q <= acc_q | (KEY_BITS'(1) << lvl_q);
			end
			node_q    <= nx;
			at_root_q <= 1'b0;
			if (!lvl_zero) begin
				lvl_q <= lvl_m1;
			end
		end
		if (cmd.set_parent) begin
			par_node_q  <= node_q;
			par_root_q  <= at_root_q;
			par_entry_q <= entry;
			par_bit_q   <= cur_bit;
			alloc_q     <= used_q + NODE_W'(1);
		end
		if (cmd.write_chain) begin
			alloc_q <= alloc_nx;
			if (!lvl_zero) begin
				lvl_q <= lvl_m1;
			end
		end
		if (cmd.load_out) begin
			out_value_q  <= (cmd.out_status == ST_OK) ? acc_q : '0;
			out_status_q <= cmd.out_status;
		end
	end

	assign out_value  = out_value_q;
	assign out_status = out_status_q;

endmodule

`default_nettype wire

// ----- rtl/btmx_ctrl.sv -----
// ----------------------------------------------------------------------------
// btmx_ctrl: trie controller
// Sequences one item at a time: accept, dispatch, walk, allocate, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ctrl import btmx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  btmx_sts_t sts,
	output btmx_cmd_t cmd
);

	btmx_state_t  state_q, state_d;
	btmx_status_t st_q, st_d;
	logic         out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			st_q        <= st_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		st_d           = st_q;
		cmd            = '0;
		cmd.out_status = st_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_START;
				end
			end
			S_START: begin
				st_d = ST_OK;
				unique case (sts.kind)
					KIND_CLEAR: begin
						cmd.clear_trie = 1'b1;
						state_d        = S_DONE;
					end
					KIND_INSERT: state_d = S_WALK;
					KIND_QUERY: begin
						if (sts.empty) begin
							st_d    = ST_EMPTY;
							state_d = S_DONE;
						end else begin
							state_d = S_WALK;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_WALK: begin
				if (sts.kind == KIND_INSERT) begin
					priority if (sts.want_miss) begin
						if (sts.fits) begin
							cmd.set_parent = 1'b1;
							state_d        = S_WR_PAR;
						end else begin
							st_d    = ST_FULL;
							state_d = S_DONE;
						end
					end else if (sts.lvl_zero) begin
						state_d = S_DONE;
					end else begin
						cmd.walk_step = 1'b1;
					end
				end else begin
					cmd.walk_step = 1'b1;
					if (sts.both_miss || sts.lvl_zero) begin
						state_d = S_DONE;
					end
				end
			end
			S_WR_PAR: begin
				cmd.write_parent = 1'b1;
				state_d          = S_WR_CHAIN;
			end
			S_WR_CHAIN: begin
				cmd.write_chain = 1'b1;
				if (sts.lvl_zero) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/binary_trie_min_xor.sv -----
// ----------------------------------------------------------------------------
// binary_trie_min_xor: binary trie with minimum-xor query
// Keys are inserted into a trie held in a node store; a query returns the
// least xor of its key against any stored key. Clear empties the trie.
// ----------------------------------------------------------------------------
//
// channel   direction  tdata                        tuser
// s_axis    in         [29:0] key_value, [31:30] 0  [1:0] kind
// m_axis    out        [29:0] min_xor_value, rest 0 [1:0] status
//
// Sequence: clear, kind 3 and an empty-trie query go straight to the result;
//   other items walk the trie from the root.
//   The walk does one node-store read per key bit; a new insert then writes
//   the parent and one new node per remaining bit on the single write port.
// Reset: arst_n clears the FSM, the node count and the root links; the
//   node store itself needs no clearing (nodes are written when allocated).
// Stalls: s_axis_tready is high only between items; a finished result sits
//   in the output register while the next item is accepted and worked on.
//
`default_nettype none

module binary_trie_min_xor import btmx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// slave side
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // [29:0] key_value, upper bits zero
	input  logic [1:0]         s_axis_tuser,  // [1:0] kind
	// master side
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // [29:0] min_xor_value, upper bits zero
	output logic [1:0]         m_axis_tuser   // [1:0] status
);

	btmx_cmd_t           cmd;
	btmx_sts_t           sts;
	logic [KEY_BITS-1:0] res_value;
	logic [1:0]          res_status;

	// sequencer: one item in flight, result held for the master side
	btmx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// node store, walk registers and output register; item is latched on
	// the accepting transfer (load_item is only raised while idle)
	btmx_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_kind    (s_axis_tuser),
		.in_key     (s_axis_tdata[KEY_BITS-1:0]),
		.cmd        (cmd),
		.sts        (sts),
		.out_value  (res_value),
		.out_status (res_status)
	);

	assign m_axis_tdata = {{(TDATA_W - KEY_BITS){1'b0}}, res_value};
	assign m_axis_tuser = res_status;

endmodule

`default_nettype wire

// ----- rtl/btmx_checker.sv -----
// ----------------------------------------------------------------------------
// btmx_checker: port-level checks for binary_trie_min_xor
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_checker import btmx_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic [TDATA_W-1:0] s_axis_tdata,
	input logic [1:0]         s_axis_tuser,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]         m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after a transfer");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_EMPTY) ||
			(m_axis_tuser == ST_FULL))
		else $error("bad status code");

	// empty or full results carry a zero value
	a_zero_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
		else $error("nonzero value with error status");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1:KEY_BITS] == '0))
		else $error("tdata padding not zero");

endmodule

bind binary_trie_min_xor btmx_checker u_btmx_checker (.*);

`default_nettype wire

// ----- tb/trie_min_xor_checker.sv -----
// ----------------------------------------------------------------------------
// trie_min_xor_checker: transfer monitor and answer predictor
// Keeps a shadow copy of the trie, works out the result of every accepted
// input transfer and compares each output transfer with the oldest answer.
// ----------------------------------------------------------------------------

module trie_min_xor_checker import btmx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,
	input  logic [1:0]         s_axis_tuser,
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [TDATA_W-1:0] m_axis_tdata,
	input  logic [1:0]         m_axis_tuser,
	output int                 fail_count,
	output int                 answers_waiting,
	output int                 full_seen,
	output int                 empty_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KEY_BITS-1:0] min_xor;
		btmx_status_t        status;
	} trie_answer_t;

	// shadow trie: link 0 means no child
	int           child_tbl [NODE_COUNT][2];
	int           alloc_cnt;
	trie_answer_t answer_q [$];
	trie_answer_t fresh, oldest;
	logic [KEY_BITS-1:0] in_key;

	function automatic btmx_status_t shadow_insert(input logic [KEY_BITS-1:0] key);
		int node, nxt, need, i;
		bit missing;
		node    = 0;
		need    = 0;
		missing = 0;
		// new nodes = the level of the first missing link and every level below it
		for (i = KEY_BITS - 1; i >= 0 && !missing; i--) begin
			nxt = child_tbl[node][key[i]];
			if (nxt == 0) begin
				need    = i + 1;
				missing = 1;
			end else begin
				node = nxt;
			end
		end
		if (alloc_cnt + need > NODE_COUNT - 1)
			return ST_FULL;
		node = 0;
		for (i = KEY_BITS - 1; i >= 0; i--) begin
			nxt = child_tbl[node][key[i]];
			if (nxt == 0) begin
				alloc_cnt++;
				nxt = alloc_cnt;
				child_tbl[nxt][0]      = 0;
				child_tbl[nxt][1]      = 0;
				child_tbl[node][key[i]] = nxt;
			end
			node = nxt;
		end
		return ST_OK;
	endfunction

	function automatic btmx_status_t shadow_query(input logic [KEY_BITS-1:0] key,
			output logic [KEY_BITS-1:0] acc);
		int node, nxt, i;
		bit dead_end;
		acc = '0;
		if (alloc_cnt == 0)
			return ST_EMPTY;
		node     = 0;
		dead_end = 0;
		for (i = KEY_BITS - 1; i >= 0 && !dead_end; i--) begin
			nxt = child_tbl[node][key[i]];
			if (nxt == 0) begin
				// wanted branch absent: this bit differs, take the other one
				acc[i] = 1'b1;
				nxt    = child_tbl[node][!key[i]];
				if (nxt == 0)
					dead_end = 1;
			end
			node = nxt;
		end
		return ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NODE_COUNT; n++) begin
				child_tbl[n][0] = 0;
				child_tbl[n][1] = 0;
			end
			alloc_cnt = 0;
			answer_q.delete();
			fail_count      = 0;
			answers_waiting = 0;
			full_seen       = 0;
			empty_seen      = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_key         = s_axis_tdata[KEY_BITS-1:0];
				fresh.min_xor  = '0;
				fresh.status   = ST_OK;
				case (s_axis_tuser)
					KIND_CLEAR: begin
						alloc_cnt       = 0;
						child_tbl[0][0] = 0;
						child_tbl[0][1] = 0;
					end
					KIND_INSERT: fresh.status = shadow_insert(in_key);
					KIND_QUERY:  fresh.status = shadow_query(in_key, fresh.min_xor);
					default: ;  // unused kind: no effect
				endcase
				if (fresh.status == ST_FULL)
					full_seen++;
				if (fresh.status == ST_EMPTY)
					empty_seen++;
				answer_q = {answer_q, fresh};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (answer_q.size() == 0) begin
					$error("unexpected result: min_xor_value %h status %0d",
						m_axis_tdata[KEY_BITS-1:0], m_axis_tuser);
					fail_count++;
				end else begin
					oldest = answer_q.pop_front();
					if (m_axis_tdata[KEY_BITS-1:0] !== oldest.min_xor) begin
						$error("min_xor_value: expected %h, got %h",
							oldest.min_xor, m_axis_tdata[KEY_BITS-1:0]);
						fail_count++;
					end
					if (m_axis_tuser !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata[TDATA_W-1:KEY_BITS] !== '0) begin
						$error("tdata padding: expected 0, got %h",
							m_axis_tdata[TDATA_W-1:KEY_BITS]);
						fail_count++;
					end
				end
			end
			answers_waiting = answer_q.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top level for the binary trie min-xor block
// Drives clear, insert, query and unused-kind transfers with random gaps and
// output stalls; the checker predicts every answer and counts mismatches.
// ----------------------------------------------------------------------------

module testbench import btmx_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;      // not decoded by the block
	localparam int DIRECTED_ITEMS = 19;
	localparam int RANDOM_ITEMS   = 1331;
	localparam int DRAIN_CYCLES   = 45;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;   // [29:0] key_value, [31:30] zero
	logic [1:0]         s_axis_tuser;   // [1:0] kind
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;   // [29:0] min_xor_value, [31:30] zero
	logic [1:0]         m_axis_tuser;   // [1:0] status

	int fail_count, answers_waiting, full_seen, empty_seen;

	// quiet: no sender gaps and no receiver stalls for the current session
	bit quiet;
	int cycles;
	int n_sent, n_insert, n_query, n_clear, n_unused;
	logic [KEY_BITS-1:0] stored_keys [$];

	binary_trie_min_xor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	trie_min_xor_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.fail_count      (fail_count),
		.answers_waiting (answers_waiting),
		.full_seen       (full_seen),
		.empty_seen      (empty_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d answers outstanding",
					cycles, answers_waiting);
				$display("testbench failed");
				$finish;
			end
		end
	end

	// mostly zero or short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// output-side back-pressure
	initial begin
		int hold;
		hold = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else if (!quiet && $urandom_range(0, 99) < 20) begin
				m_axis_tready <= 1'b0;
				hold = gap_len();
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// one input transfer; returns at the edge that accepts it
	task automatic send_item(input logic [1:0] kind, input logic [KEY_BITS-1:0] key);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {{(TDATA_W-KEY_BITS){1'b0}}, key};
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
		case (kind)
			KIND_CLEAR: begin
				n_clear++;
				stored_keys.delete();
			end
			KIND_INSERT: begin
				n_insert++;
				stored_keys = {stored_keys, key};
			end
			KIND_QUERY: n_query++;
			default:    n_unused++;
		endcase
	endtask

	function automatic logic [KEY_BITS-1:0] rand_key();
		logic [31:0] raw;
		int r;
		raw = $urandom();
		r   = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return KEY_ONES;
		return raw[KEY_BITS-1:0];
	endfunction

	// clustered keys share a long prefix with the session base
	function automatic logic [KEY_BITS-1:0] make_key(input bit clustered,
			input logic [KEY_BITS-1:0] base);
		logic [31:0] raw;
		logic [KEY_BITS-1:0] mask;
		if (!clustered)
			return rand_key();
		raw  = $urandom();
		mask = (KEY_ONES >> (KEY_BITS - $urandom_range(1, 12)));
		return base ^ (raw[KEY_BITS-1:0] & mask);
	endfunction

	// queries often land on or next to a stored key
	function automatic logic [KEY_BITS-1:0] query_key(input bit clustered,
			input logic [KEY_BITS-1:0] base);
		logic [KEY_BITS-1:0] key;
		if (stored_keys.size() == 0 || $urandom_range(0, 99) < 55)
			return make_key(clustered, base);
		key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
		if ($urandom_range(0, 1))
			key[$urandom_range(0, KEY_BITS - 1)] ^= 1'b1;
		return key;
	endfunction

	// usually a clear, then a run of inserts and queries, with a little noise;
	// the long fill sessions run the node pool out
	task automatic run_session();
		int style, len, ins_pct, n, r;
		bit clustered;
		logic [KEY_BITS-1:0] base;
		quiet = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 99) < 85)
			send_item(KIND_CLEAR, rand_key());
		style = $urandom_range(0, 99);
		clustered = 0;
		if (style < 20) begin
			len     = $urandom_range(150, 210);
			ins_pct = 75;
		end else if (style < 60) begin
			len       = $urandom_range(20, 60);
			ins_pct   = 50;
			clustered = 1;
		end else begin
			len     = $urandom_range(3, 30);
			ins_pct = 45;
		end
		base = rand_key();
		for (n = 0; n < len && n_sent < DIRECTED_ITEMS + RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				send_item(KIND_UNUSED, rand_key());
			else if (r < 5)
				send_item(KIND_CLEAR, rand_key());
			else if (r < 5 + ins_pct * 95 / 100)
				send_item(KIND_INSERT, make_key(clustered, base));
			else
				send_item(KIND_QUERY, query_key(clustered, base));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = KIND_CLEAR;
		quiet         = 1'b0;
		n_sent   = 0;
		n_insert = 0;
		n_query  = 0;
		n_clear  = 0;
		n_unused = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-trie query, extreme keys, duplicate, unused kind,
		// clear with a nonzero key, query after clear
		send_item(KIND_QUERY,  30'h2AAAAAAA);
		send_item(KIND_INSERT, 30'h00000000);
		send_item(KIND_INSERT, KEY_ONES);
		send_item(KIND_QUERY,  30'h00000000);
		send_item(KIND_QUERY,  KEY_ONES);
		send_item(KIND_QUERY,  30'h20000000);
		send_item(KIND_QUERY,  30'h15555555);
		send_item(KIND_INSERT, 30'h00000000);
		send_item(KIND_UNUSED, KEY_ONES);
		send_item(KIND_INSERT, 30'h2AAAAAAA);
		send_item(KIND_QUERY,  30'h2AAAAAAB);
		send_item(KIND_CLEAR,  KEY_ONES);
		send_item(KIND_QUERY,  30'h00000000);
		send_item(KIND_INSERT, 30'h15555555);
		send_item(KIND_QUERY,  30'h2AAAAAAA);
		send_item(KIND_UNUSED, 30'h00000000);
		send_item(KIND_INSERT, 30'h00000001);
		send_item(KIND_QUERY,  30'h00000000);
		send_item(KIND_CLEAR,  30'h00000000);

		while (n_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
			run_session();
		s_axis_tvalid <= 1'b0;
		quiet = 1'b0;

		// sample away from the active edge so the checker has settled
		do @(negedge clk); while (answers_waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transfers in %0d cycles: %0d inserts (%0d refused, pool full),",
			n_sent, cycles, n_insert, full_seen);
		$display("%0d queries (%0d on an empty trie), %0d clears, %0d of unused kind",
			n_query, empty_seen, n_clear, n_unused);
		if (fail_count == 0 && answers_waiting == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches, %0d answers never delivered",
				fail_count, answers_waiting);
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/btmx_pkg.sv
rtl/btmx_dp.sv
rtl/btmx_ctrl.sv
rtl/binary_trie_min_xor.sv
rtl/btmx_checker.sv
tb/trie_min_xor_checker.sv
tb/testbench.sv
